// ===== sv/chs_pkg.sv =====
// ----------------------------------------------------------------------------
// chs_pkg
// shared types, codes and defaults of the chained hash set unit
// ----------------------------------------------------------------------------
package chs_pkg;

  // key width, fixed by the stream format
  localparam int unsigned KEY_W = 31;

  // default sizes
  localparam int unsigned BUCKETS_DEF    = 16;
  localparam int unsigned POOL_NODES_DEF = 64;

  // key bits consumed per cycle when the bucket count is no power of two
  localparam int unsigned MOD_STEP = 4;

  // operation codes carried in tuser
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // write enables of the node store
  typedef struct packed {
    logic key_we;
    logic link_we;
  } node_wr_t;

endpackage

// ===== sv/chs_bucket_mod.sv =====
// ----------------------------------------------------------------------------
// chs_bucket_mod
// bucket index unit: key modulo the bucket count, a mask for powers of two,
// otherwise a restoring remainder that takes MOD_STEP key bits per cycle
// ----------------------------------------------------------------------------
module chs_bucket_mod #(
  parameter int unsigned BUCKETS = chs_pkg::BUCKETS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [chs_pkg::KEY_W-1:0]    key_i,
  output logic                         done_o,
  output logic [$clog2(BUCKETS)-1:0]   bucket_o
);
  import chs_pkg::*;

  localparam int unsigned BktW   = $clog2(BUCKETS);
  localparam bit          IsPow2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  logic [BktW-1:0] rem_q;
  logic            done_q;

  generate
    if (IsPow2) begin : g_mask
      // low key bits are the bucket
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          done_q <= 1'b0;
        end else begin
          done_q <= start_i;
        end
      end

      always_ff @(posedge clk_i) begin
        if (start_i) begin
          rem_q <= key_i[BktW-1:0];
        end
      end
    end else begin : g_div
      localparam int unsigned PadW   = ((KEY_W + MOD_STEP - 1) / MOD_STEP) * MOD_STEP;
      localparam int unsigned NSteps = PadW / MOD_STEP;
      localparam int unsigned CntW   = $clog2(NSteps + 1);

      logic [PadW-1:0] sh_q;
      logic [CntW-1:0] cnt_q;
      logic [BktW-1:0] rem_nx;

      // MOD_STEP restoring steps on the narrow remainder
      always_comb begin
        logic [BktW:0]   t;
        logic [BktW-1:0] r;
        r = rem_q;
        t = '0;
        for (int unsigned i = 0; i < MOD_STEP; i++) begin
          t = {r, sh_q[PadW-1-i]};
          if (t >= (BktW+1)'(BUCKETS)) begin
            t = t - (BktW+1)'(BUCKETS);
          end
          r = t[BktW-1:0];
        end
        rem_nx = r;
      end

      // step counter and done pulse
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          cnt_q  <= '0;
          done_q <= 1'b0;
        end else if (start_i) begin
          cnt_q  <= CntW'(NSteps);
          done_q <= 1'b0;
        end else if (cnt_q != '0) begin
          cnt_q  <= cnt_q - 1'b1;
          done_q <= (cnt_q == CntW'(1));
        end else begin
          done_q <= 1'b0;
        end
      end

      // key shifter and partial remainder
      always_ff @(posedge clk_i) begin
        if (start_i) begin
          sh_q  <= PadW'(key_i);
          rem_q <= '0;
        end else if (cnt_q != '0) begin
          sh_q  <= sh_q << MOD_STEP;
          rem_q <= rem_nx;
        end
      end
    end
  endgenerate

  assign done_o   = done_q;
  assign bucket_o = rem_q;

endmodule

// ===== sv/chs_head_mem.sv =====
// ----------------------------------------------------------------------------
// chs_head_mem
// chain head per bucket: one write port, one registered read port
// ----------------------------------------------------------------------------
module chs_head_mem #(
  parameter int unsigned BUCKETS    = chs_pkg::BUCKETS_DEF,
  parameter int unsigned POOL_NODES = chs_pkg::POOL_NODES_DEF
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [$clog2(BUCKETS)-1:0]         waddr_i,
  input  logic [$clog2(POOL_NODES+1)-1:0]    wdata_i,
  input  logic [$clog2(BUCKETS)-1:0]         raddr_i,
  output logic [$clog2(POOL_NODES+1)-1:0]    rdata_o
);
  import chs_pkg::*;

  localparam int unsigned NodeW = $clog2(POOL_NODES + 1);

  logic [NodeW-1:0] mem_q [BUCKETS];
  logic [NodeW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/chs_node_mem.sv =====
// ----------------------------------------------------------------------------
// chs_node_mem
// node pool: key and next link of each node, one write and one read port
// ----------------------------------------------------------------------------
module chs_node_mem #(
  parameter int unsigned POOL_NODES = chs_pkg::POOL_NODES_DEF
) (
  input  logic                               clk_i,
  input  chs_pkg::node_wr_t                  wr_i,
  input  logic [$clog2(POOL_NODES)-1:0]      waddr_i,
  input  logic [chs_pkg::KEY_W-1:0]          wkey_i,
  input  logic [$clog2(POOL_NODES+1)-1:0]    wlink_i,
  input  logic [$clog2(POOL_NODES)-1:0]      raddr_i,
  output logic [chs_pkg::KEY_W-1:0]          rkey_o,
  output logic [$clog2(POOL_NODES+1)-1:0]    rlink_o
);
  import chs_pkg::*;

  localparam int unsigned NodeW = $clog2(POOL_NODES + 1);

  logic [KEY_W-1:0] key_mem_q  [POOL_NODES];
  logic [NodeW-1:0] link_mem_q [POOL_NODES];
  logic [KEY_W-1:0] rkey_q;
  logic [NodeW-1:0] rlink_q;

  // key store
  always_ff @(posedge clk_i) begin
    if (wr_i.key_we) begin
      key_mem_q[waddr_i] <= wkey_i;
    end
    rkey_q <= key_mem_q[raddr_i];
  end

  // link store
  always_ff @(posedge clk_i) begin
    if (wr_i.link_we) begin
      link_mem_q[waddr_i] <= wlink_i;
    end
    rlink_q <= link_mem_q[raddr_i];
  end

  assign rkey_o  = rkey_q;
  assign rlink_o = rlink_q;

endmodule

// ===== sv/chained_hash_set_unit.sv =====
// ----------------------------------------------------------------------------
// chained_hash_set_unit
// hash set with separate chaining over a fixed node pool, one operation a beat
// ----------------------------------------------------------------------------
// latency, accept to result valid: every operation passes S_MOD, S_DISPATCH, S_RESP,
//   an insert also S_ALLOC when it reuses a freed node, search and delete S_WALK_RD
//   and S_WALK_CMP per chain node compared, a delete hit S_DEL_UNLINK and S_DEL_FREE
// throughput: one operation at a time, the next beat is taken in the cycle the
//   result turns valid; the chain walk, one key compare per node through the node
//   store read port, sets the rate; a bucket count that is no power of two adds
//   remainder steps in S_MOD; reset: a clearing pass empties the chain heads, tready low
// ----------------------------------------------------------------------------
module chained_hash_set_unit #(
  parameter int unsigned BUCKETS    = chs_pkg::BUCKETS_DEF,
  parameter int unsigned POOL_NODES = chs_pkg::POOL_NODES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beat
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] key, [31] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  // result beat
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [1:0] status, [2] hit, [7:3] zero
);
  import chs_pkg::*;

  localparam int unsigned BktW  = $clog2(BUCKETS);
  localparam int unsigned AddrW = $clog2(POOL_NODES);
  localparam int unsigned NodeW = $clog2(POOL_NODES + 1);
  localparam logic [NodeW-1:0] Nil = NodeW'(POOL_NODES);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_DISPATCH,
    S_ALLOC,
    S_WALK_RD,
    S_WALK_CMP,
    S_DEL_UNLINK,
    S_DEL_FREE,
    S_RESP
  } state_e;

  state_e            state_q, state_d;
  logic [BktW-1:0]   clr_q, clr_d;
  logic [NodeW-1:0]  fresh_q, fresh_d;
  logic [NodeW-1:0]  free_head_q, free_head_d;
  logic              m_valid_q, m_valid_d;

  kind_e             kind_q, kind_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [NodeW-1:0]  cur_q, cur_d;
  logic [NodeW-1:0]  prev_q, prev_d;
  logic [NodeW-1:0]  steps_q, steps_d;
  logic [1:0]        res_status_q, res_status_d;
  logic              res_hit_q, res_hit_d;
  logic [1:0]        m_status_q, m_status_d;
  logic              m_hit_q, m_hit_d;

  logic              mod_start;
  logic              mod_done;
  logic [BktW-1:0]   bucket;

  logic              head_we;
  logic [BktW-1:0]   head_waddr;
  logic [NodeW-1:0]  head_wdata;
  logic [NodeW-1:0]  head_rdata;

  node_wr_t          node_wr;
  logic [AddrW-1:0]  node_waddr;
  logic [NodeW-1:0]  node_wlink;
  logic [AddrW-1:0]  node_raddr;
  logic [KEY_W-1:0]  node_rkey;
  logic [NodeW-1:0]  node_rlink;

  // bucket of the current key
  assign mod_start = (state_q == S_IDLE) && s_axis_tvalid;

  chs_bucket_mod #(
    .BUCKETS (BUCKETS)
  ) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mod_start),
    .key_i    (s_axis_tdata[KEY_W-1:0]),
    .done_o   (mod_done),
    .bucket_o (bucket)
  );

  chs_head_mem #(
    .BUCKETS    (BUCKETS),
    .POOL_NODES (POOL_NODES)
  ) u_heads (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (bucket),
    .rdata_o (head_rdata)
  );

  // allocation reads the free list head, everything else the walk pointer
  assign node_raddr = ((state_q == S_DISPATCH) || (state_q == S_ALLOC)) ?
                      free_head_q[AddrW-1:0] : cur_q[AddrW-1:0];

  chs_node_mem #(
    .POOL_NODES (POOL_NODES)
  ) u_nodes (
    .clk_i   (clk_i),
    .wr_i    (node_wr),
    .waddr_i (node_waddr),
    .wkey_i  (key_q),
    .wlink_i (node_wlink),
    .raddr_i (node_raddr),
    .rkey_o  (node_rkey),
    .rlink_o (node_rlink)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    fresh_d      = fresh_q;
    free_head_d  = free_head_q;
    m_valid_d    = m_valid_q;
    kind_d       = kind_q;
    key_d        = key_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    steps_d      = steps_q;
    res_status_d = res_status_q;
    res_hit_d    = res_hit_q;
    m_status_d   = m_status_q;
    m_hit_d      = m_hit_q;

    head_we      = 1'b0;
    head_waddr   = bucket;
    head_wdata   = Nil;
    node_wr      = '0;
    node_waddr   = cur_q[AddrW-1:0];
    node_wlink   = head_rdata;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_q;
        head_wdata = Nil;
        clr_d      = clr_q + 1'b1;
        if (clr_q == BktW'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid) begin
          key_d   = s_axis_tdata[KEY_W-1:0];
          kind_d  = kind_e'(s_axis_tuser);
          state_d = S_MOD;
        end
      end

      S_MOD: begin
        if (mod_done) begin
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_hit_d = 1'b0;
        unique case (kind_q)
          KIND_INSERT: begin
            if (free_head_q != Nil) begin
              state_d = S_ALLOC;
            end else if (fresh_q != Nil) begin
              // take a never used node and push it at the chain head
              node_wr.key_we  = 1'b1;
              node_wr.link_we = 1'b1;
              node_waddr      = fresh_q[AddrW-1:0];
              node_wlink      = head_rdata;
              head_we         = 1'b1;
              head_wdata      = fresh_q;
              fresh_d         = fresh_q + 1'b1;
              res_status_d    = ST_OK;
              state_d         = S_RESP;
            end else begin
              res_status_d = ST_FULL;
              state_d      = S_RESP;
            end
          end
          KIND_SEARCH, KIND_DELETE: begin
            cur_d   = head_rdata;
            prev_d  = Nil;
            steps_d = '0;
            if (head_rdata == Nil) begin
              res_status_d = ST_MISS;
              state_d      = S_RESP;
            end else begin
              state_d = S_WALK_RD;
            end
          end
          default: begin
            res_status_d = ST_MISS;
            state_d      = S_RESP;
          end
        endcase
      end

      S_ALLOC: begin
        // reuse a freed node, its link is the next free node
        node_wr.key_we  = 1'b1;
        node_wr.link_we = 1'b1;
        node_waddr      = free_head_q[AddrW-1:0];
        node_wlink      = head_rdata;
        head_we         = 1'b1;
        head_wdata      = free_head_q;
        free_head_d     = node_rlink;
        res_status_d    = ST_OK;
        res_hit_d       = 1'b0;
        state_d         = S_RESP;
      end

      S_WALK_RD: begin
        state_d = S_WALK_CMP;
      end

      S_WALK_CMP: begin
        if (node_rkey == key_q) begin
          if (kind_q == KIND_DELETE) begin
            state_d = S_DEL_UNLINK;
          end else begin
            res_status_d = ST_OK;
            res_hit_d    = 1'b1;
            state_d      = S_RESP;
          end
        end else begin
          prev_d  = cur_q;
          cur_d   = node_rlink;
          steps_d = steps_q + 1'b1;
          if ((node_rlink == Nil) || (steps_q == NodeW'(POOL_NODES - 1))) begin
            res_status_d = ST_MISS;
            res_hit_d    = 1'b0;
            state_d      = S_RESP;
          end else begin
            state_d = S_WALK_RD;
          end
        end
      end

      S_DEL_UNLINK: begin
        // bypass the matched node
        if (prev_q == Nil) begin
          head_we    = 1'b1;
          head_wdata = node_rlink;
        end else begin
          node_wr.link_we = 1'b1;
          node_waddr      = prev_q[AddrW-1:0];
          node_wlink      = node_rlink;
        end
        state_d = S_DEL_FREE;
      end

      S_DEL_FREE: begin
        // push the node on the free list
        node_wr.link_we = 1'b1;
        node_waddr      = cur_q[AddrW-1:0];
        node_wlink      = free_head_q;
        free_head_d     = cur_q;
        res_status_d    = ST_OK;
        res_hit_d       = 1'b1;
        state_d         = S_RESP;
      end

      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_hit_d    = res_hit_q;
          state_d    = S_IDLE;
        end
      end
    endcase
  end

  // control state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      fresh_q     <= '0;
      free_head_q <= Nil;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      fresh_q     <= fresh_d;
      free_head_q <= free_head_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // operation payload and result data
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    key_q        <= key_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    steps_q      <= steps_d;
    res_status_q <= res_status_d;
    res_hit_q    <= res_hit_d;
    m_status_q   <= m_status_d;
    m_hit_q      <= m_hit_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, m_hit_q, m_status_q};

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the chained hash set unit: a shadow hash table
// predicts status and hit of every operation beat, and each result beat is
// compared with the oldest prediction; directed corner cases come first,
// then bursts of random inserts, searches and deletes that fill the pool,
// drain it and build long chains, under random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb_top;
  import chs_pkg::*;

  localparam int unsigned N_BUCKETS  = BUCKETS_DEF;
  localparam int unsigned N_NODES    = POOL_NODES_DEF;
  localparam int unsigned LINK_W     = $clog2(N_NODES + 1);
  localparam int unsigned NULL_LINK  = N_NODES;
  localparam int unsigned RANDOM_OPS = 1900;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned DRAIN_WAIT = 300;
  localparam int unsigned RECENT_MAX = 96;
  localparam int unsigned POOL_KEYS  = 32;

  // operation code that the block does not define
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic       hit;
  } outcome_t;

  // shadow hash table and queue of predicted outcomes
  class hash_set_scoreboard;
    logic [LINK_W-1:0] chain_head [N_BUCKETS];
    logic [KEY_W-1:0]  node_key   [N_NODES];
    logic [LINK_W-1:0] node_next  [N_NODES];
    logic [LINK_W-1:0] free_list;
    outcome_t          pending_q [$];
    int unsigned       n_errors;
    int unsigned       n_ops;
    int unsigned       n_by_kind [4];
    int unsigned       n_hits;
    int unsigned       n_full;
    int unsigned       longest_walk;

    function new();
      for (int i = 0; i < N_BUCKETS; i++) chain_head[i] = LINK_W'(NULL_LINK);
      // free list runs through the whole pool in order
      for (int i = 0; i < N_NODES; i++) begin
        node_key[i]  = '0;
        node_next[i] = LINK_W'(i + 1);
      end
      for (int i = 0; i < 4; i++) n_by_kind[i] = 0;
      free_list    = '0;
      n_errors     = 0;
      n_ops        = 0;
      n_hits       = 0;
      n_full       = 0;
      longest_walk = 0;
    endfunction

    // apply one accepted operation and queue its outcome
    function void note_op(logic [1:0] kind, logic [KEY_W-1:0] key);
      outcome_t          res;
      int unsigned       b;
      int unsigned       steps;
      logic [LINK_W-1:0] cur;
      logic [LINK_W-1:0] prev;
      logic [LINK_W-1:0] slot;
      bit                matched;
      res.status = ST_MISS;
      res.hit    = 1'b0;
      b          = key % N_BUCKETS;
      n_ops++;
      n_by_kind[kind]++;
      case (kind)
        KIND_INSERT: begin
          if (free_list == LINK_W'(NULL_LINK)) begin
            res.status = ST_FULL;
            n_full++;
          end else begin
            // pop the free list, push at the chain head
            slot            = free_list;
            free_list       = node_next[slot];
            node_key[slot]  = key;
            node_next[slot] = chain_head[b];
            chain_head[b]   = slot;
            res.status      = ST_OK;
          end
        end
        KIND_SEARCH, KIND_DELETE: begin
          prev    = LINK_W'(NULL_LINK);
          cur     = chain_head[b];
          steps   = 0;
          matched = 1'b0;
          while (!matched && cur < N_NODES && steps < N_NODES) begin
            if (node_key[cur] == key) begin
              matched = 1'b1;
            end else begin
              prev = cur;
              cur  = node_next[cur];
              steps++;
            end
          end
          if (steps > longest_walk) longest_walk = steps;
          if (matched) begin
            res.status = ST_OK;
            res.hit    = 1'b1;
            n_hits++;
            // unlink the first match and hand it back to the free list
            if (kind == KIND_DELETE) begin
              if (prev != LINK_W'(NULL_LINK)) node_next[prev] = node_next[cur];
              else chain_head[b] = node_next[cur];
              node_next[cur] = free_list;
              free_list      = cur;
            end
          end
        end
        default: ;
      endcase
      pending_q.push_back(res);
    endfunction

    // compare one result beat with the oldest prediction
    function void check_result(logic [7:0] beat);
      outcome_t expd;
      outcome_t got;
      got.status = beat[1:0];
      got.hit    = beat[2];
      if (pending_q.size() == 0) begin
        n_errors++;
        $display("%0t: result beat with none pending: status %0d hit %0d",
                 $time, got.status, got.hit);
        return;
      end
      expd = pending_q.pop_front();
      if (got.status != expd.status) begin
        n_errors++;
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, expd.status, got.status);
      end
      if (got.hit != expd.hit) begin
        n_errors++;
        $display("%0t: hit mismatch: expected %0d actual %0d",
                 $time, expd.hit, got.hit);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;

  hash_set_scoreboard sb = new();

  logic [KEY_W-1:0] key_pool [POOL_KEYS];
  logic [KEY_W-1:0] recent_keys [$];
  int unsigned      n_random;
  int unsigned      idle_cycles = 0;

  chained_hash_set_unit #(
    .BUCKETS   (N_BUCKETS),
    .POOL_NODES(N_NODES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // beat monitor on both sides
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_op(s_axis_tuser, s_axis_tdata[KEY_W-1:0]);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stalls, switching among several patterns
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned period;
    int unsigned tick;
    logic        rdy;
    m_axis_tready <= 1'b0;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(20, 300);
      period = $urandom_range(2, 7);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = ($urandom_range(0, 1) != 0);
          2:       rdy = ($urandom_range(0, 4) == 0);
          default: rdy = ((tick % period) != 0);
        endcase
        tick++;
        m_axis_tready <= rdy;
      end
    end
  end

  // present one beat and hold it until accepted
  task automatic send_op(logic [1:0] kind, logic [KEY_W-1:0] key);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, key};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // hold off the sender until every predicted result has come back
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // fresh key set, most keys crowded into the n_hot hot buckets
  task automatic refresh_key_pool(int unsigned n_hot);
    int unsigned      hot [4];
    int unsigned      bucket;
    logic [KEY_W-1:0] upper;
    for (int i = 0; i < 4; i++) hot[i] = $urandom_range(0, N_BUCKETS - 1);
    for (int i = 0; i < POOL_KEYS; i++) begin
      upper  = KEY_W'($urandom());
      bucket = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, n_hot - 1)]
                                           : $urandom_range(0, N_BUCKETS - 1);
      key_pool[i] = KEY_W'(upper - (upper % N_BUCKETS) + bucket);
    end
  endtask

  // key for a random operation, searches and deletes favor stored keys
  function automatic logic [KEY_W-1:0] pick_key(logic [1:0] kind);
    int unsigned      r;
    int unsigned      idx;
    logic [KEY_W-1:0] key;
    r = $urandom_range(0, 99);
    if (kind != KIND_INSERT && recent_keys.size() > 0 && r < 70) begin
      idx = $urandom_range(0, recent_keys.size() - 1);
      key = recent_keys[idx];
      if (kind == KIND_DELETE) recent_keys.delete(idx);
    end else if (r < 85) begin
      key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
    end else if (r < 95) begin
      key = KEY_W'($urandom());
    end else begin
      case ($urandom_range(0, 2))
        0:       key = '0;
        1:       key = '1;
        default: key = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
      endcase
    end
    if (kind == KIND_INSERT) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > RECENT_MAX) void'(recent_keys.pop_front());
    end
    return key;
  endfunction

  // bursts of random operations with a given insert/search/delete mix
  task automatic run_phase(int unsigned n, int unsigned w_ins, int unsigned w_srch,
                           int unsigned w_del);
    int unsigned done_ops;
    int unsigned burst;
    int unsigned gap;
    int unsigned r;
    logic [1:0]  kind;
    done_ops = 0;
    while (done_ops < n) begin
      burst = $urandom_range(1, 24);
      if (burst > n - done_ops) burst = n - done_ops;
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < w_ins) kind = KIND_INSERT;
        else if (r < w_ins + w_srch) kind = KIND_SEARCH;
        else if (r < w_ins + w_srch + w_del) kind = KIND_DELETE;
        else kind = KIND_UNUSED;
        send_op(kind, pick_key(kind));
        done_ops++;
        n_random++;
      end
      // gap between bursts, sometimes none
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // main sequence
  initial begin
    int unsigned n_cycle;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_INSERT;
    n_random = 0;
    n_cycle  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, unused code
    send_op(KIND_SEARCH, '0);
    send_op(KIND_DELETE, '1);
    send_op(KIND_UNUSED, KEY_W'(5));
    // duplicates of the largest key, newest removed first
    send_op(KIND_INSERT, '0);
    send_op(KIND_INSERT, '1);
    send_op(KIND_INSERT, '1);
    send_op(KIND_SEARCH, '1);
    send_op(KIND_DELETE, '1);
    send_op(KIND_SEARCH, '1);
    send_op(KIND_DELETE, '1);
    send_op(KIND_SEARCH, '1);
    send_op(KIND_DELETE, '1);
    // one bucket with three nodes: tail hit, middle unlink, head hit, miss, tail unlink
    send_op(KIND_INSERT, KEY_W'(16));
    send_op(KIND_INSERT, KEY_W'(32));
    send_op(KIND_SEARCH, '0);
    send_op(KIND_DELETE, KEY_W'(16));
    send_op(KIND_SEARCH, KEY_W'(32));
    send_op(KIND_SEARCH, KEY_W'(48));
    send_op(KIND_DELETE, '0);
    // alternating bit patterns
    send_op(KIND_INSERT, 31'h2AAA_AAAA);
    send_op(KIND_INSERT, 31'h5555_5555);
    send_op(KIND_SEARCH, 31'h2AAA_AAAA);
    send_op(KIND_UNUSED, '1);
    wait_for_drain();

    // fill to a full pool, mixed traffic, then drain; first round with one hot bucket
    while (n_random < RANDOM_OPS) begin
      refresh_key_pool((n_cycle == 0) ? 1 : $urandom_range(2, 4));
      run_phase(190, 70, 20, 8);
      run_phase(120, 30, 40, 28);
      run_phase(165, 15, 25, 58);
      wait_for_drain();
      n_cycle++;
    end

    // let stray beats show up
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d operations: %0d inserts, %0d searches, %0d deletes, %0d unused code",
             sb.n_ops, sb.n_by_kind[KIND_INSERT], sb.n_by_kind[KIND_SEARCH],
             sb.n_by_kind[KIND_DELETE], sb.n_by_kind[KIND_UNUSED]);
    $display("%0d key matches, %0d inserts refused on a full pool, longest walk %0d nodes",
             sb.n_hits, sb.n_full, sb.longest_walk);
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/chs_pkg.sv
sv/chs_bucket_mod.sv
sv/chs_head_mem.sv
sv/chs_node_mem.sv
sv/chained_hash_set_unit.sv
sim/tb_top.sv
